@@ rtl/core/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int DATA_W        = 32;
	localparam int CAP_W         = 11;
	localparam int COUNT_W       = 11;
	localparam int DEPTH_DEFAULT = 1024;

	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	// operation codes carried in the kind field
	typedef enum logic [1:0] {
		KIND_INS_FRONT = 2'd0,
		KIND_INS_REAR  = 2'd1,
		KIND_DEL_FRONT = 2'd2,
		KIND_DEL_REAR  = 2'd3
	} kind_t;

	// controller states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_WORK = 1'b1
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic issue;   // request word taken: update pointers, hit the store
		logic finish;  // store data is back: load the result register
	} cmd_t;

endpackage

@@ rtl/core/bdq_ifs.sv @@
// ----------------------------------------------------------------------------
// bdq_ifs
// Valid/ready channels for deque requests and responses.
// ----------------------------------------------------------------------------
interface bdq_req_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   kind;
	logic signed [bdq_pkg::DATA_W-1:0] item_value;

	modport source (output valid, output kind, output item_value, input ready);
	modport sink   (input valid, input kind, input item_value, output ready);
endinterface

interface bdq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              accepted;
	logic signed [bdq_pkg::DATA_W-1:0] front_value;
	logic signed [bdq_pkg::DATA_W-1:0] rear_value;
	logic                              is_empty;
	logic                              is_full;
	logic [bdq_pkg::COUNT_W-1:0]       entry_count;

	modport source (output valid, output accepted, output front_value, output rear_value,
		output is_empty, output is_full, output entry_count, input ready);
	modport sink   (input valid, input accepted, input front_value, input rear_value,
		input is_empty, input is_full, input entry_count, output ready);
endinterface

@@ rtl/core/bdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bdq_ctrl
// Two-state sequencer: take a request word, then load the response once the
// store read is back and the response register is free.
// ----------------------------------------------------------------------------
module bdq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output bdq_pkg::cmd_t  cmd
);

	bdq_pkg::state_t state_q;
	bdq_pkg::state_t state_nx;
	logic            out_valid_q;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			bdq_pkg::ST_IDLE: begin
				if (in_valid) state_nx = bdq_pkg::ST_WORK;
			end
			bdq_pkg::ST_WORK: begin
				if (!out_valid_q || out_ready) state_nx = bdq_pkg::ST_IDLE;
			end
			default: state_nx = bdq_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready   = 1'b0;
		cmd.issue  = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			bdq_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.issue = in_valid;
			end
			bdq_pkg::ST_WORK: begin
				cmd.finish = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	// advance state, hold response valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bdq_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |=> !cmd.issue)
		else $error("request taken while a word is in flight");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("response register overwritten before taken");

	a_finish_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> $past(cmd.issue) || $past(state_q == bdq_pkg::ST_WORK))
		else $error("response loaded without a request");
`endif

endmodule

@@ rtl/core/bdq_datapath.sv @@
// ----------------------------------------------------------------------------
// bdq_datapath
// Ring store, head pointer, count, cached end values and response register.
// ----------------------------------------------------------------------------
module bdq_datapath #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bdq_pkg::cmd_t                      cmd,
	input  logic                               cfg_wr_en,
	input  logic [bdq_pkg::CAP_W-1:0]          cfg_wr_data,
	input  logic [1:0]                         kind,
	input  logic signed [bdq_pkg::DATA_W-1:0]  item_value,
	output logic                               accepted,
	output logic signed [bdq_pkg::DATA_W-1:0]  front_value,
	output logic signed [bdq_pkg::DATA_W-1:0]  rear_value,
	output logic                               is_empty,
	output logic                               is_full,
	output logic [bdq_pkg::COUNT_W-1:0]        entry_count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int WW = (CW > bdq_pkg::CAP_W) ? CW : bdq_pkg::CAP_W;
	localparam logic [PW:0]   DEPTH_X = (PW + 1)'(DEPTH);
	localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);
	localparam logic [PW-1:0] LAST    = PW'(DEPTH - 1);

	function automatic logic [PW-1:0] wrap(input logic [PW:0] x);
		return (x >= DEPTH_X) ? PW'(x - DEPTH_X) : PW'(x);
	endfunction

	logic [bdq_pkg::DATA_W-1:0] mem_q [DEPTH];
	logic [bdq_pkg::DATA_W-1:0] rd_q;
	logic [bdq_pkg::CAP_W-1:0]  cap_q;
	logic [PW-1:0]              head_q;
	logic [CW-1:0]              count_q;
	logic [bdq_pkg::DATA_W-1:0] front_q;
	logic [bdq_pkg::DATA_W-1:0] rear_q;
	logic                       ok_q;
	logic                       ref_front_q;
	logic                       ref_rear_q;

	logic [bdq_pkg::DATA_W-1:0] res_front_q;
	logic [bdq_pkg::DATA_W-1:0] res_rear_q;
	logic                       res_ok_q;
	logic                       res_empty_q;
	logic                       res_full_q;
	logic [bdq_pkg::COUNT_W-1:0] res_count_q;

	logic [WW-1:0]  cap_w;
	logic [WW-1:0]  cap_eff;
	logic [WW-1:0]  count_w;
	logic           full;
	logic           empty;
	logic           ok;
	logic           wr_en;
	logic           rd_en;
	logic [PW-1:0]  wr_addr;
	logic [PW-1:0]  rd_addr;
	logic [PW-1:0]  head_nx;
	logic [CW-1:0]  count_nx;
	logic           set_front;
	logic           set_rear;
	logic           ref_front;
	logic           ref_rear;
	logic [PW-1:0]  head_dec;
	logic [PW-1:0]  head_inc;
	logic [PW-1:0]  tail_idx;
	logic [PW-1:0]  rear_del_idx;
	logic [bdq_pkg::DATA_W-1:0] front_nx;
	logic [bdq_pkg::DATA_W-1:0] rear_nx;
	bdq_pkg::kind_t op;

	// capacity, saturated to the store depth
	assign cap_w   = WW'(cap_q);
	assign cap_eff = (cap_w > DEPTH_W) ? DEPTH_W : cap_w;
	assign count_w = WW'(count_q);
	assign full    = count_w >= cap_eff;
	assign empty   = (count_q == '0);

	// slot arithmetic on the ring
	assign head_dec     = (head_q == '0) ? LAST : head_q - PW'(1);
	assign head_inc     = wrap({1'b0, head_q} + (PW + 1)'(1));
	assign tail_idx     = wrap({1'b0, head_q} + (PW + 1)'(count_q));
	assign rear_del_idx = wrap({1'b0, head_q} + (PW + 1)'(count_q) - (PW + 1)'(2));

	// decode the operation
	always_comb begin
		op        = bdq_pkg::kind_t'(kind);
		ok        = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		wr_addr   = tail_idx;
		rd_addr   = head_inc;
		head_nx   = head_q;
		count_nx  = count_q;
		set_front = 1'b0;
		set_rear  = 1'b0;
		ref_front = 1'b0;
		ref_rear  = 1'b0;
		unique case (op)
			bdq_pkg::KIND_INS_FRONT: begin
				ok        = !full;
				wr_en     = ok;
				wr_addr   = head_dec;
				head_nx   = ok ? head_dec : head_q;
				count_nx  = ok ? count_q + CW'(1) : count_q;
				set_front = ok;
				set_rear  = ok && empty;
			end
			bdq_pkg::KIND_INS_REAR: begin
				ok        = !full;
				wr_en     = ok;
				wr_addr   = tail_idx;
				count_nx  = ok ? count_q + CW'(1) : count_q;
				set_rear  = ok;
				set_front = ok && empty;
			end
			bdq_pkg::KIND_DEL_FRONT: begin
				ok        = !empty;
				head_nx   = ok ? head_inc : head_q;
				count_nx  = ok ? count_q - CW'(1) : count_q;
				rd_addr   = head_inc;
				ref_front = ok && (count_nx != '0);
				rd_en     = ref_front;
			end
			bdq_pkg::KIND_DEL_REAR: begin
				ok        = !empty;
				count_nx  = ok ? count_q - CW'(1) : count_q;
				rd_addr   = rear_del_idx;
				ref_rear  = ok && (count_nx != '0);
				rd_en     = ref_rear;
			end
			default: ;
		endcase
	end

	// ring store: one write or one registered read per request
	always_ff @(posedge clk) begin
		if (cmd.issue && wr_en) mem_q[wr_addr] <= item_value;
		if (cmd.issue && rd_en) rd_q <= mem_q[rd_addr];
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= bdq_pkg::CAP_RESET;
		else if (cfg_wr_en) cap_q <= cfg_wr_data;
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.issue) begin
			head_q  <= head_nx;
			count_q <= count_nx;
		end
	end

	// end values after the store read returns
	assign front_nx = ref_front_q ? rd_q : front_q;
	assign rear_nx  = ref_rear_q  ? rd_q : rear_q;

	// cached end values and per-request flags
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			ok_q        <= ok;
			ref_front_q <= ref_front;
			ref_rear_q  <= ref_rear;
			if (set_front) front_q <= item_value;
			if (set_rear)  rear_q  <= item_value;
		end else if (cmd.finish) begin
			front_q     <= front_nx;
			rear_q      <= rear_nx;
			ref_front_q <= 1'b0;
			ref_rear_q  <= 1'b0;
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_ok_q    <= ok_q;
			res_empty_q <= empty;
			res_full_q  <= full;
			res_count_q <= count_w[bdq_pkg::COUNT_W-1:0];
			res_front_q <= empty ? '1 : front_nx;
			res_rear_q  <= empty ? '1 : rear_nx;
		end
	end

	assign accepted    = res_ok_q;
	assign front_value = res_front_q;
	assign rear_value  = res_rear_q;
	assign is_empty    = res_empty_q;
	assign is_full     = res_full_q;
	assign entry_count = res_count_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_w <= DEPTH_W)
		else $error("count beyond store depth");

	a_refused_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue && !ok |=> head_q == $past(head_q) && count_q == $past(count_q))
		else $error("refused operation changed the deque");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && empty |=> res_front_q == '1 && res_rear_q == '1)
		else $error("empty deque reported an end value");
`endif

endmodule

@@ rtl/core/bounded_double_ended_queue_unit.sv @@
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_unit
// Bounded deque of signed 32-bit values in a ring store with a writable
// capacity.
//
//   channel   dir   handshake        payload
//   request   in    valid/ready      kind, item_value
//   response  out   valid/ready      accepted, front/rear value, flags, count
//   cfg       in    cfg_wr_en        cfg_wr_data (capacity)
//
// Each request word is taken in the idle state, which updates the pointers and
// writes or reads the ring store; the work state then brings the registered
// read data into the response register. A new word is taken while the
// previous response waits. A stalled response holds the work state until the register frees up.
// No clearing pass after reset; the block is ready at once.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_unit #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [bdq_pkg::CAP_W-1:0] cfg_wr_data,
	bdq_req_if.sink                   request,
	bdq_rsp_if.source                 response
);

	bdq_pkg::cmd_t cmd;

	// sequencer
	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.out_valid (response.valid),
		.out_ready (response.ready),
		.cmd       (cmd)
	);

	// store and result path
	bdq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.kind        (request.kind),
		.item_value  (request.item_value),
		.accepted    (response.accepted),
		.front_value (response.front_value),
		.rear_value  (response.rear_value),
		.is_empty    (response.is_empty),
		.is_full     (response.is_full),
		.entry_count (response.entry_count)
	);

endmodule

@@ tb/tb_bounded_double_ended_queue_unit.sv @@
// ----------------------------------------------------------------------------
// tb_bounded_double_ended_queue_unit
// Self-checking bench for the bounded deque. It runs a short scripted
// sequence, then random phases at many capacities, from zero to the
// saturated top code. Each request word is mirrored by a shadow deque, and
// every response word is compared field by field against it. Both channels
// idle at random, and the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module tb_bounded_double_ended_queue_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS     = bdq_pkg::DEPTH_DEFAULT;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int WORD_W    = bdq_pkg::DATA_W;
	localparam int CNT_W     = bdq_pkg::COUNT_W;
	localparam int CFG_W     = bdq_pkg::CAP_W;
	localparam int EXP_SLOTS = 16;
	localparam int ROW_SLOTS = 32;

	localparam logic signed [WORD_W-1:0] WORD_MAX  = 32'sh7fff_ffff;
	localparam logic signed [WORD_W-1:0] WORD_MIN  = 32'sh8000_0000;
	localparam logic signed [WORD_W-1:0] WORD_NONE = -32'sd1;

	typedef struct packed {
		logic                     accepted;
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] rear_value;
		logic                     is_empty;
		logic                     is_full;
		logic [CNT_W-1:0]         entry_count;
	} deque_status_t;

	typedef struct packed {
		logic                     is_cap_write;
		logic [CFG_W-1:0]         cap;
		bdq_pkg::kind_t           kind;
		logic signed [WORD_W-1:0] value;
		logic                     has_status;
		deque_status_t            status;
	} script_row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;

	bdq_req_if req();
	bdq_rsp_if rsp();

	bounded_double_ended_queue_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.request     (req),
		.response    (rsp)
	);

	// shadow deque
	logic signed [WORD_W-1:0] mirror_ring [SLOTS];
	logic [SLOT_W-1:0]        mirror_head;
	logic [CNT_W-1:0]         mirror_count;
	logic [CFG_W-1:0]         mirror_cap;

	deque_status_t expected_ring [EXP_SLOTS];
	int            expected_wr;
	int            expected_rd;
	script_row_t   script [ROW_SLOTS];
	int            script_len;
	int            mismatch_count;
	int            words_checked;
	int            tx_idle_pct;
	int            rx_idle_pct;
	bit            long_hold_done;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// number of response words still owed
	function automatic int expected_level();
		return expected_wr - expected_rd;
	endfunction

	task automatic log_expected(deque_status_t st);
		expected_ring[expected_wr % EXP_SLOTS] = st;
		expected_wr++;
	endtask

	function automatic void append_row(script_row_t row);
		script[script_len] = row;
		script_len++;
	endfunction

	function automatic logic [CNT_W-1:0] usable_cap();
		return (mirror_cap > CFG_W'(SLOTS)) ? CNT_W'(SLOTS) : mirror_cap;
	endfunction

	// apply one operation to the shadow deque and report the status after it
	function automatic deque_status_t apply_deque_op(bdq_pkg::kind_t kind,
		logic signed [WORD_W-1:0] value);
		logic [CNT_W-1:0]  limit;
		logic [SLOT_W-1:0] slot;
		deque_status_t     st;
		limit = usable_cap();
		st.accepted = 1'b0;
		case (kind)
			bdq_pkg::KIND_INS_FRONT: begin
				if (mirror_count < limit) begin
					mirror_head = mirror_head - SLOT_W'(1);
					mirror_ring[mirror_head] = value;
					mirror_count++;
					st.accepted = 1'b1;
				end
			end
			bdq_pkg::KIND_INS_REAR: begin
				if (mirror_count < limit) begin
					slot = mirror_head + mirror_count[SLOT_W-1:0];
					mirror_ring[slot] = value;
					mirror_count++;
					st.accepted = 1'b1;
				end
			end
			bdq_pkg::KIND_DEL_FRONT: begin
				if (mirror_count != 0) begin
					mirror_head = mirror_head + SLOT_W'(1);
					mirror_count--;
					st.accepted = 1'b1;
				end
			end
			default: begin
				if (mirror_count != 0) begin
					mirror_count--;
					st.accepted = 1'b1;
				end
			end
		endcase
		st.is_empty    = (mirror_count == 0);
		st.is_full     = (mirror_count >= limit);
		st.entry_count = mirror_count;
		st.front_value = WORD_NONE;
		st.rear_value  = WORD_NONE;
		if (!st.is_empty) begin
			slot = mirror_head + mirror_count[SLOT_W-1:0] - SLOT_W'(1);
			st.front_value = mirror_ring[mirror_head];
			st.rear_value  = mirror_ring[slot];
		end
		return st;
	endfunction

	function automatic deque_status_t status(logic acc, logic signed [WORD_W-1:0] front,
		logic signed [WORD_W-1:0] rear, logic empty, logic full, logic [CNT_W-1:0] n);
		status = '{acc, front, rear, empty, full, n};
	endfunction

	function automatic script_row_t op_row(bdq_pkg::kind_t kind,
		logic signed [WORD_W-1:0] value);
		op_row = '{1'b0, '0, kind, value, 1'b0, '0};
	endfunction

	function automatic script_row_t checked_row(bdq_pkg::kind_t kind,
		logic signed [WORD_W-1:0] value, deque_status_t st);
		checked_row = '{1'b0, '0, kind, value, 1'b1, st};
	endfunction

	function automatic script_row_t cap_row(logic [CFG_W-1:0] cap);
		cap_row = '{1'b1, cap, bdq_pkg::KIND_INS_FRONT, '0, 1'b0, '0};
	endfunction

	// drop valid and hold until every outstanding response word is back
	task automatic settle_results();
		req.valid <= 1'b0;
		while (expected_level() != 0)
			@(posedge clk);
	endtask

	task automatic reconfigure(logic [CFG_W-1:0] cap);
		settle_results();
		repeat (3) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en  <= 1'b0;
		mirror_cap = cap;
	endtask

	// offer one request word, hold it until taken, then log its status
	task automatic offer_word(bdq_pkg::kind_t kind, logic signed [WORD_W-1:0] value,
		logic has_status, deque_status_t typed);
		deque_status_t predicted;
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req.valid      <= 1'b1;
		req.kind       <= kind;
		req.item_value <= value;
		do @(posedge clk); while (!req.ready);
		predicted = apply_deque_op(kind, value);
		log_expected(has_status ? typed : predicted);
	endtask

	// random words: fill toward full, then drain toward empty, with some noise
	task automatic run_phase(logic [CFG_W-1:0] cap, int n_words, bit steep, int idle_pct,
		bit pause_midway);
		bit                       filling;
		bit                       want_insert;
		int                       bias;
		bdq_pkg::kind_t           kind;
		logic signed [WORD_W-1:0] value;
		reconfigure(cap);
		tx_idle_pct = idle_pct;
		rx_idle_pct = idle_pct;
		filling = 1'b1;
		bias = steep ? 99 : 75;
		for (int i = 0; i < n_words; i++) begin
			if (pause_midway && i == n_words / 2)
				settle_results();
			if (filling && mirror_count >= usable_cap())
				filling = 1'b0;
			else if (!filling && mirror_count == 0)
				filling = 1'b1;
			if ($urandom_range(0, 99) < (steep ? 1 : 10))
				want_insert = 1'($urandom_range(0, 1));
			else if (filling)
				want_insert = ($urandom_range(0, 99) < bias);
			else
				want_insert = ($urandom_range(0, 99) >= bias);
			if (want_insert)
				kind = $urandom_range(0, 1) ? bdq_pkg::KIND_INS_REAR : bdq_pkg::KIND_INS_FRONT;
			else
				kind = $urandom_range(0, 1) ? bdq_pkg::KIND_DEL_REAR : bdq_pkg::KIND_DEL_FRONT;
			case ($urandom_range(0, 9))
				0:       value = WORD_MAX;
				1:       value = WORD_MIN;
				2:       value = WORD_NONE;
				3:       value = '0;
				default: value = $urandom;
			endcase
			offer_word(kind, value, 1'b0, '0);
		end
	endtask

	// compare one response field
	task automatic report_field(string name, logic signed [WORD_W-1:0] want,
		logic signed [WORD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// check each response word against the oldest expectation
	always @(posedge clk) begin
		deque_status_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			words_checked++;
			if (expected_level() == 0) begin
				$error("response word with no request outstanding");
				mismatch_count++;
			end else begin
				want = expected_ring[expected_rd % EXP_SLOTS];
				expected_rd++;
				report_field("accepted", WORD_W'(want.accepted), WORD_W'(rsp.accepted));
				report_field("front_value", want.front_value, rsp.front_value);
				report_field("rear_value", want.rear_value, rsp.rear_value);
				report_field("is_empty", WORD_W'(want.is_empty), WORD_W'(rsp.is_empty));
				report_field("is_full", WORD_W'(want.is_full), WORD_W'(rsp.is_full));
				report_field("entry_count", WORD_W'(want.entry_count),
					WORD_W'(rsp.entry_count));
			end
		end
	end

	// response side: random stalls, plus one long hold to back up the request side
	initial begin
		rsp.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!long_hold_done && words_checked >= 300) begin
				long_hold_done = 1'b1;
				rsp.ready <= 1'b0;
				repeat (80) @(posedge clk);
			end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 8) - 1) @(posedge clk);
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n         <= 1'b0;
		cfg_wr_en      <= 1'b0;
		cfg_wr_data    <= '0;
		req.valid      <= 1'b0;
		req.kind       <= bdq_pkg::KIND_INS_FRONT;
		req.item_value <= '0;
		mismatch_count = 0;
		words_checked  = 0;
		expected_wr    = 0;
		expected_rd    = 0;
		script_len     = 0;
		long_hold_done = 1'b0;
		tx_idle_pct    = 20;
		rx_idle_pct    = 20;
		mirror_head    = '0;
		mirror_count   = '0;
		mirror_cap     = bdq_pkg::CAP_RESET;

		// empty deque, value extremes, capacity lowered below the count,
		// capacity zero, capacity above the store depth
		append_row(checked_row(bdq_pkg::KIND_DEL_FRONT, 32'sh1234_5678,
			status(1'b0, WORD_NONE, WORD_NONE, 1'b1, 1'b0, 11'd0)));
		append_row(checked_row(bdq_pkg::KIND_DEL_REAR, '0,
			status(1'b0, WORD_NONE, WORD_NONE, 1'b1, 1'b0, 11'd0)));
		append_row(checked_row(bdq_pkg::KIND_INS_REAR, WORD_MAX,
			status(1'b1, WORD_MAX, WORD_MAX, 1'b0, 1'b0, 11'd1)));
		append_row(checked_row(bdq_pkg::KIND_INS_FRONT, WORD_MIN,
			status(1'b1, WORD_MIN, WORD_MAX, 1'b0, 1'b0, 11'd2)));
		append_row(checked_row(bdq_pkg::KIND_INS_FRONT, WORD_NONE,
			status(1'b1, WORD_NONE, WORD_MAX, 1'b0, 1'b0, 11'd3)));
		append_row(op_row(bdq_pkg::KIND_INS_REAR, '0));
		append_row(op_row(bdq_pkg::KIND_DEL_REAR, 32'sh5a5a_5a5a));
		append_row(op_row(bdq_pkg::KIND_DEL_FRONT, 32'sh0f0f_0f0f));
		append_row(cap_row(11'd1));
		append_row(op_row(bdq_pkg::KIND_INS_REAR, 32'sh0000_0005));
		append_row(op_row(bdq_pkg::KIND_INS_FRONT, 32'sh0000_0006));
		append_row(op_row(bdq_pkg::KIND_DEL_FRONT, '0));
		append_row(op_row(bdq_pkg::KIND_DEL_REAR, '0));
		append_row(op_row(bdq_pkg::KIND_INS_FRONT, 32'sh5555_5555));
		append_row(op_row(bdq_pkg::KIND_INS_REAR, 32'shaaaa_aaaa));
		append_row(cap_row(11'd0));
		append_row(checked_row(bdq_pkg::KIND_DEL_REAR, '0,
			status(1'b1, WORD_NONE, WORD_NONE, 1'b1, 1'b1, 11'd0)));
		append_row(checked_row(bdq_pkg::KIND_INS_REAR, 32'shaaaa_aaaa,
			status(1'b0, WORD_NONE, WORD_NONE, 1'b1, 1'b1, 11'd0)));
		append_row(checked_row(bdq_pkg::KIND_INS_FRONT, 32'sh5555_5555,
			status(1'b0, WORD_NONE, WORD_NONE, 1'b1, 1'b1, 11'd0)));
		append_row(checked_row(bdq_pkg::KIND_DEL_FRONT, '0,
			status(1'b0, WORD_NONE, WORD_NONE, 1'b1, 1'b1, 11'd0)));
		append_row(cap_row(11'd2047));
		append_row(op_row(bdq_pkg::KIND_INS_FRONT, 32'sh0000_0001));
		append_row(op_row(bdq_pkg::KIND_INS_REAR, WORD_MIN));
		append_row(op_row(bdq_pkg::KIND_DEL_FRONT, '0));
		append_row(op_row(bdq_pkg::KIND_DEL_REAR, '0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the script
		for (int i = 0; i < script_len; i++) begin
			if (script[i].is_cap_write)
				reconfigure(script[i].cap);
			else
				offer_word(script[i].kind, script[i].value, script[i].has_status,
					script[i].status);
		end

		// random phases: small capacities first, then a fill to the store depth,
		// then a capacity well below the count; no idling in the last two
		run_phase(11'd0, 40, 1'b0, 30, 1'b0);
		run_phase(11'd1, 80, 1'b0, 0, 1'b0);
		run_phase(11'd2, 80, 1'b0, 50, 1'b0);
		run_phase(CFG_W'($urandom_range(3, 8)), 120, 1'b0, 25, 1'b0);
		run_phase(CFG_W'($urandom_range(9, 40)), 200, 1'b0, 15, 1'b1);
		run_phase(11'd2047, 1100, 1'b1, 10, 1'b0);
		run_phase(11'd700, 60, 1'b0, 0, 1'b0);
		run_phase(11'd1024, 120, 1'b0, 0, 1'b0);

		settle_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_level() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
